@@ design/thb_pkg.sv @@
// thb_pkg: shared types and constants for the time histogram binner
// no dependencies
package thb_pkg;

  localparam int TIME_BITS = 32;
  localparam int NB_BITS   = 11;
  localparam int SEL_BITS  = 10;

  typedef enum logic [1:0] {
    REG_NUM_BINS   = 2'd0,
    REG_FIRST_EDGE = 2'd1,
    REG_LAST_EDGE  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DV_IDLE = 2'd0,
    DV_RUN  = 2'd1,
    DV_DONE = 2'd2
  } div_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR = 3'd0,
    BK_IDLE  = 3'd1,
    BK_READ  = 3'd2,
    BK_WRITE = 3'd3,
    BK_OUT   = 3'd4
  } back_state_t;

  // classified work item passed from front to back
  typedef struct packed {
    logic        is_read;
    logic        ok;
    logic [15:0] bin;
  } job_t;

endpackage

@@ design/thb_front.sv @@
// thb_front: accepts input beats, range checks them and finds the bin index
// uses thb_pkg; bin index by restoring division, one quotient bit per cycle
module thb_front import thb_pkg::*; #(
  parameter int MAX_BINS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 action,
  input  logic [TIME_BITS-1:0] event_time,
  input  logic [SEL_BITS-1:0]  bin_select,
  input  logic [NB_BITS-1:0]   num_bins,
  input  logic [TIME_BITS-1:0] first_edge,
  input  logic [TIME_BITS-1:0] last_edge,
  output logic                 job_valid,
  input  logic                 job_ready,
  output job_t                 job
);

  localparam int PB = TIME_BITS + NB_BITS; // product width
  localparam int QB = NB_BITS;             // quotient < nb <= 2^(NB_BITS-1)
  localparam int CB = $clog2(QB + 1);

  div_state_t state, state_next;
  logic [PB-1:0]        rem;
  logic [TIME_BITS-1:0] span;
  logic [QB-1:0]        quo;
  logic [CB-1:0]        cnt;
  job_t                 job_r;

  logic [NB_BITS-1:0]   nb;
  logic [TIME_BITS-1:0] off;
  logic                 drop;
  logic [PB+1:0]        trial;
  logic [PB:0]          rem_sh;

  always_comb begin
    nb = (num_bins > NB_BITS'(MAX_BINS)) ? NB_BITS'(MAX_BINS) : num_bins;
    off = event_time - first_edge;
    drop = (nb == '0) || (last_edge <= first_edge) || (event_time < first_edge) ||
           (event_time >= last_edge);
    // shifted remainder can reach 2*span<<(PB-32), one bit above rem
    rem_sh = {rem, 1'b0};
    trial = {1'b0, rem_sh} - {2'b00, span, {(PB-TIME_BITS){1'b0}}};
  end

  always_comb begin
    state_next = state;
    case (state)
      DV_IDLE: if (in_valid) begin
        state_next = (action || drop) ? DV_DONE : DV_RUN;
      end
      DV_RUN:  if (cnt == CB'(QB - 1)) state_next = DV_DONE;
      DV_DONE: if (job_ready) state_next = DV_IDLE;
      default: state_next = DV_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == DV_IDLE);
    job_valid = (state == DV_DONE);
    job       = job_r;
    if (!job_r.is_read && job_r.ok) job.bin = 16'(quo);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= DV_IDLE;
    else     state <= state_next;
  end

  // dividend sits in the low bits; each step shifts one bit against span<<(PB-32)
  always_ff @(posedge clk) begin
    case (state)
      DV_IDLE: if (in_valid) begin
        rem   <= PB'(off) * PB'(nb);
        span  <= last_edge - first_edge;
        quo   <= '0;
        cnt   <= '0;
        job_r.is_read <= action;
        job_r.ok      <= action ? (11'(bin_select) < nb) : !drop;
        job_r.bin     <= action ? 16'(bin_select) : '0;
      end
      DV_RUN: begin
        cnt <= cnt + 1'b1;
        if (!trial[PB+1]) begin
          rem <= trial[PB-1:0];
          quo <= {quo[QB-2:0], 1'b1};
        end else begin
          rem <= rem_sh[PB-1:0];
          quo <= {quo[QB-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/thb_queue.sv @@
// thb_queue: two-entry queue between classifier and counter engine
// uses thb_pkg for the job type
module thb_queue import thb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  job_t       slots [2];
  logic       wp, rp;
  logic [1:0] fill;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_job   = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= !wp;
      if (rd_valid && rd_ready) rp <= !rp;
      fill <= fill + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) slots[wp] <= wr_job;
  end

endmodule

@@ design/thb_back.sv @@
// thb_back: counter memory with read-modify-write and result register
// uses thb_pkg; clears the memory after reset, one entry a cycle
module thb_back import thb_pkg::*; #(
  parameter int MAX_BINS   = 1024,
  parameter int COUNT_BITS = 48,
  parameter int IDX_BITS   = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  job_t                  job,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  res_ok,
  output logic [SEL_BITS-1:0]   res_bin,
  output logic [COUNT_BITS-1:0] res_count
);

  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  back_state_t state, state_next;
  logic [IDX_BITS:0]     clr;
  job_t                  cur;
  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS-1:0] inc;

  assign inc = (&rd_data) ? rd_data : rd_data + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      BK_CLEAR: if (clr == (IDX_BITS+1)'(MAX_BINS - 1)) state_next = BK_IDLE;
      BK_IDLE:  if (job_valid) state_next = job.ok ? BK_READ : BK_OUT;
      BK_READ:  state_next = cur.is_read ? BK_OUT : BK_WRITE;
      BK_WRITE: state_next = BK_OUT;
      BK_OUT:   if (out_ready) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == BK_IDLE);
    out_valid = (state == BK_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) clr <= '0;
    else if (state == BK_CLEAR) clr <= clr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == BK_CLEAR) mem[clr[IDX_BITS-1:0]] <= '0;
    else if (state == BK_WRITE) mem[cur.bin[IDX_BITS-1:0]] <= inc;
    rd_data <= mem[(state == BK_IDLE ? job.bin[IDX_BITS-1:0] : cur.bin[IDX_BITS-1:0])];
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: if (job_valid) begin
        cur       <= job;
        res_ok    <= job.ok;
        res_bin   <= job.ok || job.is_read ? job.bin[SEL_BITS-1:0] : '0;
        res_count <= '0;
      end
      BK_READ:  if (cur.is_read) res_count <= rd_data;
      BK_WRITE: res_count <= inc;
      default: ;
    endcase
  end

endmodule

@@ design/time_histogram_binner_top.sv @@
// time_histogram_binner_top: equal-width event time histogram
// uses thb_pkg, thb_front, thb_queue, thb_back
//
// channel | dir | contents
// s_axis  | in  | tdata[31:0] event_time, [41:32] bin_select; tuser action
// m_axis  | out | tdata[47:0] bin_count, [57:48] bin_number; tuser in_range
// apb     | in  | 0x0 num_bins, 0x4 first_edge, 0x8 last_edge
//
// a counted fill goes through the bit-serial bin division in the front, then
// the counter read-modify-write in the back; an in-range read skips the division
// and only reads the counter, a dropped fill or out-of-range read touches neither
// the front takes no new beat while it divides or until its job is handed to the queue
// after reset the counter memory is cleared entry by entry; beats are taken
// and queued meanwhile, but no result leaves until the clear is done
// front and back run on their own behind a two-entry queue
module time_histogram_binner_top import thb_pkg::*; #(
  parameter int MAX_BINS   = 1024,
  parameter int COUNT_BITS = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // event_time, bin_select
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // bin_count, bin_number
  output logic        m_axis_tuser,  // in_range
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_BITS = $clog2(MAX_BINS);

  logic [NB_BITS-1:0]   num_bins;
  logic [TIME_BITS-1:0] first_edge, last_edge;
  logic                 fq_valid, fq_ready, qb_valid, qb_ready;
  job_t                 fq_job, qb_job;
  logic [SEL_BITS-1:0]  res_bin;
  logic [COUNT_BITS-1:0] res_count;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins   <= 11'd1024;
      first_edge <= '0;
      last_edge  <= 32'd65536;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_NUM_BINS:   num_bins   <= pwdata[NB_BITS-1:0];
        REG_FIRST_EDGE: first_edge <= pwdata;
        REG_LAST_EDGE:  last_edge  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NUM_BINS:   prdata = 32'(num_bins);
      REG_FIRST_EDGE: prdata = first_edge;
      REG_LAST_EDGE:  prdata = last_edge;
      default:        prdata = '0;
    endcase
  end

  thb_front #(.MAX_BINS(MAX_BINS)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .action(s_axis_tuser), .event_time(s_axis_tdata[31:0]),
    .bin_select(s_axis_tdata[41:32]),
    .num_bins, .first_edge, .last_edge,
    .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
  );

  thb_queue u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
  );

  thb_back #(.MAX_BINS(MAX_BINS), .COUNT_BITS(COUNT_BITS), .IDX_BITS(IDX_BITS)) u_back (
    .clk, .rst,
    .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .res_ok(m_axis_tuser), .res_bin, .res_count
  );

  assign m_axis_tdata = {6'd0, res_bin, 48'(res_count)};

endmodule

@@ design/thb_checker.sv @@
// thb_checker: port-level checks on the histogram binner
// bound to time_histogram_binner_top
module thb_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        pready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped while stalled");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[47:0] == 48'd0)
    else $error("dropped item with nonzero count");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[63:58] == 6'd0)
    else $error("padding bits set");

  a_ready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind time_histogram_binner_top thb_checker u_thb_checker (
  .clk, .rst, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .pready
);

@@ bench/testbench.sv @@
// testbench: stream-driven check of time_histogram_binner_top against a local bin predictor
// depends on thb_pkg and time_histogram_binner_top
module testbench;
  import thb_pkg::*;

  localparam int NBINS  = 1024;
  localparam logic [47:0] CMAX = 48'hFFFF_FFFF_FFFF;
  localparam int LIMIT  = 400000;

  typedef struct packed {
    logic        action;
    logic [31:0] event_time;
    logic [9:0]  bin_select;
  } req_t;

  typedef struct packed {
    logic        in_range;
    logic [9:0]  bin_number;
    logic [47:0] bin_count;
  } res_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // [31:0] event_time, [41:32] bin_select
  logic s_axis_tuser = 0;          // action
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [63:0] m_axis_tdata;       // [47:0] bin_count, [57:48] bin_number
  logic m_axis_tuser;              // in_range
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  time_histogram_binner_top uut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state: the histogram as the block should hold it
  logic [47:0] hist [NBINS];
  logic [10:0] cfg_bins = 11'd1024;
  logic [31:0] cfg_lo = 0;
  logic [31:0] cfg_hi = 32'd65536;

  req_t pending_beats[$];
  res_t expected_bins[$];
  int   errors = 0;
  int   cycles = 0;
  bit   feeding = 0;

  function automatic res_t bin_event(req_t r);
    res_t o;
    logic [10:0] nb;
    logic [63:0] span, off, idx;
    nb = (cfg_bins > 11'd1024) ? 11'd1024 : cfg_bins;
    o = '0;
    if (r.action) begin
      o.bin_number = r.bin_select;
      if ({1'b0, r.bin_select} < nb) begin
        o.in_range = 1;
        o.bin_count = hist[r.bin_select];
      end
    end else if (nb != 0 && cfg_hi > cfg_lo && r.event_time >= cfg_lo &&
                 r.event_time < cfg_hi) begin
      span = cfg_hi - cfg_lo;
      off  = r.event_time - cfg_lo;
      idx  = (off * nb) / span;
      if (idx >= nb) idx = nb - 1;
      if (hist[idx] != CMAX) hist[idx] = hist[idx] + 1;
      o.in_range = 1;
      o.bin_number = idx[9:0];
      o.bin_count = hist[idx];
    end
    return o;
  endfunction

  // driver: bursts with random gaps
  int burst = 0, gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_bins.push_back(bin_event(pending_beats.pop_front()));
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the beat
      end else if (gap > 0 || pending_beats.size() == 0 || !feeding) begin
        s_axis_tvalid <= 0;
        if (gap > 0) gap <= gap - 1;
      end else begin
        // the next beat is at the front once the accepted one was popped
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {6'd0, pending_beats[0].bin_select, pending_beats[0].event_time};
        s_axis_tuser  <= pending_beats[0].action;
        if (burst > 0) burst <= burst - 1;
        else begin
          burst <= $urandom_range(0, 12);
          gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver: stall pattern of its own, with some stall-free stretches
  int phase = 0;
  always @(posedge clk) begin
    phase <= phase + 1;
    if (rst) m_axis_tready <= 0;
    else if ((phase / 64) % 3 == 0) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 9) < 6);
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bins.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = expected_bins.pop_front();
        if (m_axis_tuser !== e.in_range) begin
          $display("%0t: in_range exp %0d got %0d", $time, e.in_range, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[57:48] !== e.bin_number) begin
          $display("%0t: bin_number exp %0d got %0d", $time, e.bin_number,
                   m_axis_tdata[57:48]);
          errors++;
        end
        if (m_axis_tdata[47:0] !== e.bin_count) begin
          $display("%0t: bin_count exp %0d got %0d", $time, e.bin_count,
                   m_axis_tdata[47:0]);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_NUM_BINS:   cfg_bins = val[10:0];
      REG_FIRST_EDGE: cfg_lo = val;
      default:        cfg_hi = val;
    endcase
  endtask

  task automatic queue_beat(logic act, logic [31:0] t, logic [9:0] sel);
    req_t r;
    r.action = act; r.event_time = t; r.bin_select = sel;
    pending_beats.push_back(r);
  endtask

  // run the queued beats and wait for every result plus the fill latency
  task automatic drain();
    feeding = 1;
    wait (pending_beats.size() == 0);
    @(posedge clk);
    while (s_axis_tvalid) @(posedge clk);
    feeding = 0;
    wait (expected_bins.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  // mostly times inside the range, with edges and far outliers
  function automatic logic [31:0] pick_time();
    logic [31:0] span;
    span = cfg_hi - cfg_lo;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return cfg_lo - $urandom_range(0, 3);
      2: return cfg_hi - $urandom_range(0, 2);
      default: return (cfg_hi > cfg_lo) ? cfg_lo + $urandom_range(0, span - 1) : $urandom;
    endcase
  endfunction

  // reads favor the bins in use, with some past them
  task automatic random_phase(int n, int max_bins);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0)
          queue_beat(1, $urandom, 10'($urandom_range(0, max_bins - 1)));
        else
          queue_beat(1, $urandom, 10'($urandom_range(0, 1023)));
      end else
        queue_beat(0, pick_time(), 10'($urandom));
    end
    drain();
  endtask

  initial begin
    foreach (hist[i]) hist[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 0;
    // counters are cleared entry by entry after reset; wait for the clear
    repeat (NBINS + 20) @(posedge clk);

    // directed: reset config, range edges, read extremes
    queue_beat(0, 32'd0, 10'd0);
    queue_beat(0, 32'd65535, 10'h3FF);
    queue_beat(0, 32'd65536, 10'd0);
    queue_beat(0, 32'hFFFF_FFFF, 10'd0);
    queue_beat(0, 32'd64, 10'd0);
    queue_beat(0, 32'd64, 10'd0);
    queue_beat(1, 32'hFFFF_FFFF, 10'd1);
    queue_beat(1, 32'd0, 10'd1023);
    queue_beat(1, 32'd0, 10'd0);
    drain();
    // below first edge, fewer bins, reads past num_bins
    reg_write(REG_NUM_BINS, 32'd3);
    reg_write(REG_FIRST_EDGE, 32'd100);
    reg_write(REG_LAST_EDGE, 32'd400);
    queue_beat(0, 32'd99, 10'd0);
    queue_beat(0, 32'd100, 10'd0);
    queue_beat(0, 32'd399, 10'd0);
    queue_beat(0, 32'd400, 10'd0);
    queue_beat(1, 32'd0, 10'd2);
    queue_beat(1, 32'd0, 10'd3);
    drain();
    // inverted, empty range and zero bins
    reg_write(REG_LAST_EDGE, 32'd100);
    queue_beat(0, 32'd100, 10'd0);
    reg_write(REG_LAST_EDGE, 32'd50);
    queue_beat(0, 32'd60, 10'd0);
    drain();
    reg_write(REG_NUM_BINS, 32'd0);
    reg_write(REG_LAST_EDGE, 32'd400);
    queue_beat(0, 32'd200, 10'd0);
    queue_beat(1, 32'd0, 10'd0);
    drain();
    // oversize bin count saturates to the maximum, full 32-bit span
    reg_write(REG_NUM_BINS, 32'd2047);
    reg_write(REG_FIRST_EDGE, 32'd0);
    reg_write(REG_LAST_EDGE, 32'hFFFF_FFFF);
    queue_beat(0, 32'hFFFF_FFFE, 10'd0);
    queue_beat(1, 32'd0, 10'd1023);
    drain();

    // random phases across settings
    reg_write(REG_NUM_BINS, 32'd1);
    reg_write(REG_FIRST_EDGE, 32'h8000_0000);
    reg_write(REG_LAST_EDGE, 32'h8000_0010);
    random_phase(100, 1);
    reg_write(REG_NUM_BINS, 32'd8);
    reg_write(REG_FIRST_EDGE, 32'd1000);
    reg_write(REG_LAST_EDGE, 32'd1100);
    random_phase(150, 8);
    reg_write(REG_NUM_BINS, 32'd1024);
    reg_write(REG_FIRST_EDGE, 32'd0);
    reg_write(REG_LAST_EDGE, 32'hFFFF_FFFF);
    random_phase(150, 1024);
    reg_write(REG_NUM_BINS, $urandom_range(1, 1500));
    reg_write(REG_FIRST_EDGE, $urandom_range(0, 32'h7FFF_FFFF));
    reg_write(REG_LAST_EDGE, cfg_lo + $urandom_range(1, 32'h7FFF_FFFF));
    random_phase(150, 1024);
    reg_write(REG_NUM_BINS, 32'd37);
    reg_write(REG_FIRST_EDGE, 32'h0000_1000);
    reg_write(REG_LAST_EDGE, 32'h0000_1025);
    random_phase(100, 37);

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
